### src/i2cqws_pkg.sv
// Shared types and constants for the queued I2C write sequencer.
// Used by i2c_queued_write_sequencer; no dependencies.
`default_nettype none
package i2cqws_pkg;

  // Ring and address sizing
  localparam int QUEUE_DEPTH = 64;
  localparam int ADDR_WIDTH  = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int LEN_W       = 8;
  localparam int DESC_W      = ADDR_WIDTH + LEN_W;

  // Register reset value: device address byte, write bit clear
  localparam logic [7:0] DEV_ADDR_RESET = 8'h78;

  // Input kinds carried in tuser
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_EVENT   = 1'b1;

  // Engine states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADDR = 3'b010,
    ST_DATA = 3'b100
  } eng_state_t;

  // Bus commands issued to the I2C engine
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_ADDR  = 3'd2,
    CMD_DATA  = 3'd3,
    CMD_STOP  = 3'd4
  } bus_cmd_t;

  // Ready status after each step
  typedef enum logic [1:0] {
    RDY_BUSY  = 2'd0,
    RDY_FULL  = 2'd1,
    RDY_EMPTY = 2'd2
  } rdy_t;

  // One ring entry
  typedef struct packed {
    logic [ADDR_WIDTH-1:0] addr;
    logic [LEN_W-1:0]      len;
  } desc_t;

  // Advance a ring index with wrap
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage
`default_nettype wire

### src/i2c_queued_write_sequencer.sv
// Top level of the queued I2C master write sequencer.
// Depends on i2cqws_pkg and the i2cqws_ram descriptor store.
//
// Usage:
//   in_*  : one transfer per request. in_tuser selects the kind: 0 enqueues a
//           descriptor (buffer address, length), 1 is a bus event from the
//           I2C engine (ack missing, write collision flags).
//   out_* : one result per request, in request order: enqueue status, start
//           kick, bus command with its address or data fetch address, buffer
//           release, and the ready status after the step.
//   cfg_* : write of the device address byte (reset 0x78); always ready; the user
//           writes it only while no request is in flight (the block does not enforce this).
// Latency: a result is presented in the cycle after its request transfer.
// Throughput: one request per cycle; the descriptor RAM read for the ring
// head is issued ahead from the next head index, with a bypass for a same-cycle write.
// Stall: the single output register holds a result until out_tready; a new
// request is taken whenever that register is empty or being drained.
// Reset (rst_n low, synchronous): ring empty, engine idle, no buffer held,
// output register empty. Descriptor RAM contents need no clearing.
`default_nettype none
module i2c_queued_write_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] block_address, [23:16] block_length, [24] ack_missing,
  // [25] write_collision, [31:26] zero
  input  wire logic [31:0] in_tdata,
  // [0] req_type
  input  wire logic [0:0]  in_tuser,
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] write_status, [1] start_event, [4:2] bus_command, [12:5] address_byte,
  // [28:13] fetch_address, [29] release_buffer, [45:30] release_address,
  // [47:46] ready_status
  output logic      [47:0] out_tdata,
  // Configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);
  import i2cqws_pkg::*;

  // Request fields
  logic                  req_type;
  logic [15:0]           block_address;
  logic [LEN_W-1:0]      block_length;
  logic                  ack_missing;
  logic                  write_collision;
  logic                  in_xfer;

  // State registers
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic                  empty_r, empty_nxt;
  logic                  full_r, full_nxt;
  eng_state_t            state_r, state_nxt, state_eff;
  logic [LEN_W-1:0]      left_r, left_nxt;
  logic [ADDR_WIDTH-1:0] next_addr_r, next_addr_nxt;
  logic [ADDR_WIDTH-1:0] held_addr_r, held_addr_nxt;
  logic                  held_r, held_nxt;
  logic [7:0]            dev_addr_r;

  // Descriptor store and head bypass
  logic                  ram_we;
  desc_t                 ram_wdata;
  desc_t                 ram_rdata;
  desc_t                 byp_data_r;
  logic                  byp_hit_r;
  desc_t                 head_desc;

  // Result fields
  logic                  res_wstat;
  logic                  res_start;
  bus_cmd_t              res_cmd;
  logic [7:0]            res_abyte;
  logic [ADDR_WIDTH-1:0] res_fetch;
  logic                  res_rel;
  logic [ADDR_WIDTH-1:0] res_rel_addr;
  rdy_t                  res_rdy;

  // Output register
  logic                  out_valid_r;
  logic [47:0]           out_data_r;

  assign req_type        = in_tuser[0];
  assign block_address   = in_tdata[15:0];
  assign block_length    = in_tdata[23:16];
  assign ack_missing     = in_tdata[24];
  assign write_collision = in_tdata[25];

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Ring entry written on an accepted enqueue
  assign ram_we         = in_xfer && (req_type == REQ_ENQUEUE) && !full_r;
  assign ram_wdata.addr = ADDR_WIDTH'(block_address);
  assign ram_wdata.len  = block_length;

  i2cqws_ram #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  // Forward a write that lands on the entry being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= ram_we && (tail_r == head_nxt);
    end
    byp_data_r <= ram_wdata;
  end

  assign head_desc = byp_hit_r ? byp_data_r : ram_rdata;

  // Step the ring and the engine for one request
  assign state_eff = write_collision ? ST_IDLE : state_r;

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    full_nxt      = full_r;
    state_nxt     = state_r;
    left_nxt      = left_r;
    next_addr_nxt = next_addr_r;
    held_addr_nxt = held_addr_r;
    held_nxt      = held_r;
    res_wstat     = 1'b0;
    res_start     = 1'b0;
    res_cmd       = CMD_NONE;
    res_abyte     = '0;
    res_fetch     = '0;
    res_rel       = 1'b0;
    res_rel_addr  = '0;
    if (in_xfer) begin
      if (req_type == REQ_ENQUEUE) begin
        if (full_r) begin
          res_wstat = 1'b1;
        end else begin
          tail_nxt  = ring_next(tail_r);
          empty_nxt = 1'b0;
          full_nxt  = (ring_next(tail_r) == head_r);
          res_start = (state_r == ST_IDLE);
        end
      end else begin
        state_nxt = state_eff;
        case (state_eff)
          ST_IDLE: begin
            if (!empty_r) begin
              left_nxt      = head_desc.len;
              next_addr_nxt = head_desc.addr;
              held_addr_nxt = head_desc.addr;
              held_nxt      = 1'b1;
              head_nxt      = ring_next(head_r);
              full_nxt      = 1'b0;
              empty_nxt     = (ring_next(head_r) == tail_r);
              res_cmd       = CMD_START;
              state_nxt     = ST_ADDR;
            end
          end
          ST_ADDR: begin
            res_cmd   = CMD_ADDR;
            res_abyte = dev_addr_r;
            state_nxt = ST_DATA;
          end
          ST_DATA: begin
            if (ack_missing || (left_r == '0)) begin
              res_cmd       = CMD_STOP;
              state_nxt     = ST_IDLE;
              res_rel       = held_r;
              res_rel_addr  = held_r ? held_addr_r : '0;
              held_nxt      = 1'b0;
              held_addr_nxt = '0;
            end else begin
              left_nxt      = left_r - 1'b1;
              res_cmd       = CMD_DATA;
              res_fetch     = next_addr_r;
              next_addr_nxt = next_addr_r + 1'b1;
            end
          end
          default: begin
            // Unused state code: treat as a stop
            res_cmd       = CMD_STOP;
            state_nxt     = ST_IDLE;
            res_rel       = held_r;
            res_rel_addr  = held_r ? held_addr_r : '0;
            held_nxt      = 1'b0;
            held_addr_nxt = '0;
          end
        endcase
      end
    end
  end

  // Ready status after the step
  always_comb begin
    if (full_nxt) begin
      res_rdy = RDY_FULL;
    end else if (empty_nxt && (state_nxt == ST_IDLE)) begin
      res_rdy = RDY_EMPTY;
    end else begin
      res_rdy = RDY_BUSY;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      full_r      <= 1'b0;
      state_r     <= ST_IDLE;
      left_r      <= '0;
      next_addr_r <= '0;
      held_addr_r <= '0;
      held_r      <= 1'b0;
      dev_addr_r  <= DEV_ADDR_RESET;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      full_r      <= full_nxt;
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      next_addr_r <= next_addr_nxt;
      held_addr_r <= held_addr_nxt;
      held_r      <= held_nxt;
      if (cfg_valid && cfg_ready) begin
        dev_addr_r <= cfg_data;
      end
    end
  end

  // Output register: load on a request transfer, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (in_xfer) begin
      out_data_r <= {res_rdy, 16'(res_rel_addr), res_rel, 16'(res_fetch),
                     res_abyte, res_cmd, res_start, res_wstat};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(full_r && empty_r))
    else $error("ring flagged full and empty at once");

  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r || empty_r) |-> (head_r == tail_r))
    else $error("ring flag set with head and tail apart");

  a_flags_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) |-> (full_r || empty_r))
    else $error("head meets tail without full or empty flag");

  a_busy_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> held_r)
    else $error("engine active with no buffer held");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted request left no result");

endmodule
`default_nettype wire

### src/i2cqws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read during write returns the old contents.
`default_nettype none
module i2cqws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### bench/tb_i2c_queued_write_sequencer.sv
// Self-checking bench for the queued I2C write sequencer: directed sequences,
// random traffic under several idle/stall mixes, and a long output hold-off.
// Depends on i2cqws_pkg and i2c_queued_write_sequencer.
module tb_i2c_queued_write_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cqws_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 50;

  // One result, laid out exactly as out_tdata (first member is the top bits)
  typedef struct packed {
    rdy_t        ready;
    logic [15:0] release_addr;
    logic        release_buf;
    logic [15:0] fetch_addr;
    logic [7:0]  addr_byte;
    bus_cmd_t    cmd;
    logic        start_event;
    logic        write_status;
  } seq_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // Traffic shaping (idle and stall rates in percent of cycles) and run counters
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;

  // Shadow copy of the sequencer state
  desc_t       ring_entries [QUEUE_DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_tail = 0;
  logic        ring_is_empty = 1'b1;
  logic        ring_is_full = 1'b0;
  eng_state_t  seq_state = ST_IDLE;
  logic [7:0]  bytes_remaining = '0;
  logic [15:0] next_fetch = '0;
  logic [15:0] held_addr = '0;
  logic        holding = 1'b0;
  logic [7:0]  dev_addr_shadow = DEV_ADDR_RESET;

  seq_result_t sequencer_results_due [$];

  i2c_queued_write_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Compute the result of one accepted request and advance the shadow state
  function automatic seq_result_t next_sequencer_result(input logic kind,
      input logic [15:0] baddr, input logic [7:0] blen, input logic nack,
      input logic coll);
    seq_result_t res;
    res = '0;
    if (kind == REQ_ENQUEUE) begin
      if (ring_is_full) begin
        res.write_status = 1'b1;
      end else begin
        ring_entries[ring_tail].addr = baddr;
        ring_entries[ring_tail].len = blen;
        ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
        ring_is_empty = 1'b0;
        if (ring_tail == ring_head) ring_is_full = 1'b1;
        if (seq_state == ST_IDLE) res.start_event = 1'b1;
      end
    end else begin
      // a collision drops to idle before the event is handled
      if (coll) seq_state = ST_IDLE;
      case (seq_state)
        ST_IDLE: begin
          if (!ring_is_empty) begin
            bytes_remaining = ring_entries[ring_head].len;
            next_fetch = ring_entries[ring_head].addr;
            held_addr = ring_entries[ring_head].addr;
            holding = 1'b1;
            ring_head = (ring_head + 1) % QUEUE_DEPTH;
            ring_is_full = 1'b0;
            if (ring_head == ring_tail) ring_is_empty = 1'b1;
            res.cmd = CMD_START;
            seq_state = ST_ADDR;
          end
        end
        ST_ADDR: begin
          res.cmd = CMD_ADDR;
          res.addr_byte = dev_addr_shadow;
          seq_state = ST_DATA;
        end
        default: begin
          if (nack || bytes_remaining == 0) begin
            // stop; a missing acknowledge leaves the byte count alone
            res.cmd = CMD_STOP;
            seq_state = ST_IDLE;
            if (holding) begin
              res.release_buf = 1'b1;
              res.release_addr = held_addr;
              holding = 1'b0;
              held_addr = '0;
            end
          end else begin
            bytes_remaining--;
            res.cmd = CMD_DATA;
            res.fetch_addr = next_fetch;
            next_fetch = next_fetch + 16'd1;
          end
        end
      endcase
    end
    if (ring_is_full) res.ready = RDY_FULL;
    else if (ring_is_empty && seq_state == ST_IDLE) res.ready = RDY_EMPTY;
    else res.ready = RDY_BUSY;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
      input logic [47:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] %s mismatch: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_result(input seq_result_t got);
    seq_result_t want;
    if (sequencer_results_due.size() == 0) begin
      report_mismatch("unexpected result", got, '0);
      return;
    end
    want = sequencer_results_due.pop_front();
    if (got.write_status !== want.write_status)
      report_mismatch("write_status", got.write_status, want.write_status);
    if (got.start_event !== want.start_event)
      report_mismatch("start_event", got.start_event, want.start_event);
    if (got.cmd !== want.cmd)
      report_mismatch("bus_command", got.cmd, want.cmd);
    if (got.addr_byte !== want.addr_byte)
      report_mismatch("address_byte", got.addr_byte, want.addr_byte);
    if (got.fetch_addr !== want.fetch_addr)
      report_mismatch("fetch_address", got.fetch_addr, want.fetch_addr);
    if (got.release_buf !== want.release_buf)
      report_mismatch("release_buffer", got.release_buf, want.release_buf);
    if (got.release_addr !== want.release_addr)
      report_mismatch("release_address", got.release_addr, want.release_addr);
    if (got.ready !== want.ready)
      report_mismatch("ready_status", got.ready, want.ready);
  endtask

  // Check results, then predict requests accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready)
        sequencer_results_due.push_back(next_sequencer_result(in_tuser[0],
            in_tdata[15:0], in_tdata[23:16], in_tdata[24], in_tdata[25]));
      if (cfg_valid && cfg_ready) dev_addr_shadow = cfg_data;
    end
  end

  // Drive out_tready: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // End the run if no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** i2c_queued_write_sequencer: FAILED **");
      $finish;
    end
  end

  // Offer one request, idling first at the sender rate, and wait for the transfer
  task automatic send_item(input logic kind, input logic [15:0] baddr,
      input logic [7:0] blen, input logic nack, input logic coll);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'b0, coll, nack, blen, baddr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic enqueue(input logic [15:0] baddr, input logic [7:0] blen);
    send_item(REQ_ENQUEUE, baddr, blen, 1'b0, 1'b0);
  endtask

  task automatic bus_event(input logic nack, input logic coll);
    send_item(REQ_EVENT, $urandom_range(16'hFFFF), $urandom_range(255), nack, coll);
  endtask

  // Mostly well-formed traffic with some fully random noise
  task automatic send_random_item(input int enq_pct);
    logic       kind;
    logic [7:0] blen;
    logic       nack;
    logic       coll;
    int         lpick;
    lpick = $urandom_range(99);
    blen = (lpick < 75) ? $urandom_range(7) :
           (lpick < 97) ? $urandom_range(8, 31) : $urandom_range(255);
    if ($urandom_range(99) < 8) begin
      kind = $urandom_range(1);
      nack = $urandom_range(1);
      coll = $urandom_range(1);
    end else begin
      kind = ($urandom_range(99) < enq_pct) ? REQ_ENQUEUE : REQ_EVENT;
      nack = ($urandom_range(99) < 6);
      coll = ($urandom_range(99) < 3);
    end
    send_item(kind, $urandom_range(16'hFFFF), blen, nack, coll);
  endtask

  // Drop valid and wait until every expected result has arrived; wait for the
  // next edge first so the last accepted request is already queued
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sequencer_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_device_address(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Events on an empty ring, address wrap, zero length, missing ack, collision
  task automatic test_directed_sequences();
    in_idle_pct = 0;
    out_stall_pct = 0;
    bus_event(1'b0, 1'b0);
    bus_event(1'b1, 1'b1);
    // transfer ending at the top of the address space
    enqueue(16'hFFFE, 8'd2);
    repeat (5) bus_event(1'b0, 1'b0);
    // zero length: start, address, stop
    enqueue(16'h0000, 8'd0);
    repeat (3) bus_event(1'b0, 1'b0);
    // missing acknowledge ends the first buffer early
    enqueue(16'h1234, 8'd5);
    enqueue(16'hABCD, 8'd1);
    repeat (3) bus_event(1'b0, 1'b0);
    bus_event(1'b1, 1'b0);
    // collision mid-transfer replaces the held buffer without a release
    repeat (2) bus_event(1'b0, 1'b0);
    enqueue(16'h5555, 8'd1);
    bus_event(1'b0, 1'b1);
    repeat (3) bus_event(1'b0, 1'b0);
    wait_quiet();
  endtask

  // Random traffic across idle/stall mixes, ring fill levels and addresses
  task automatic test_random_traffic();
    int         in_pcts [4] = '{0, 58, 0, 18};
    int         out_pcts [4] = '{0, 0, 58, 18};
    int         enq_pcts [2] = '{5, 35};
    logic [7:0] dev_addrs [4];
    dev_addrs[0] = 8'h00;
    dev_addrs[1] = 8'hFF;
    dev_addrs[2] = $urandom_range(255);
    dev_addrs[3] = $urandom_range(255);
    for (int m = 0; m < 4; m++) begin
      for (int e = 0; e < 2; e++) begin
        write_device_address(e == 0 ? dev_addrs[m] : ~dev_addrs[m]);
        in_idle_pct = in_pcts[m];
        out_stall_pct = out_pcts[m];
        repeat (250) send_random_item(enq_pcts[e]);
        wait_quiet();
      end
    end
  endtask

  // Hold the result side off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_requests++;
    repeat (120) send_random_item(30);
    wait_quiet();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_sequences();
    test_random_traffic();
    test_output_backpressure();
    // flag any expected result that never showed up
    if (sequencer_results_due.size() != 0)
      report_mismatch("missing result", '0, sequencer_results_due[0]);
    if (mismatch_count == 0)
      $display("** i2c_queued_write_sequencer: PASSED **");
    else
      $display("** i2c_queued_write_sequencer: FAILED **");
    $finish;
  end

endmodule
